[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define LQS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[src/lqs_pkg.sv]
// ----------------------------------------------------------------------------
// lqs_pkg
// Types and constants for the linear queue with statistics.
// ----------------------------------------------------------------------------
package lqs_pkg;

  localparam int DEPTH     = 128;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = VAL_W + CNT_W;
  localparam int FRAC_W    = 8;
  localparam int DIV_W     = SUM_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int AVG_W     = 40;
  localparam int COUNT_W   = 8;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_STATS = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAUNCH,
    S_DIV
  } state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] data;
    logic [COUNT_W-1:0]      count;
    logic signed [VAL_W-1:0] max_value;
    logic signed [VAL_W-1:0] min_value;
    logic signed [AVG_W-1:0] average;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctl_t;

endpackage

[src/lqs_cell.sv]
// ----------------------------------------------------------------------------
// lqs_cell
// One queue slot: loads a new value, takes its neighbor's, or takes the head.
// ----------------------------------------------------------------------------
module lqs_cell (
  input  logic                             clk,
  input  lqs_pkg::cell_ctl_t               ctl,
  input  logic signed [lqs_pkg::VAL_W-1:0] in_value,
  input  logic signed [lqs_pkg::VAL_W-1:0] next_value,
  input  logic signed [lqs_pkg::VAL_W-1:0] head_value,
  output logic signed [lqs_pkg::VAL_W-1:0] q
);
  import lqs_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= in_value;
    end else if (ctl.wrap) begin
      q <= head_value;
    end else if (ctl.shift) begin
      q <= next_value;
    end
  end

endmodule

[src/lqs_div.sv]
// ----------------------------------------------------------------------------
// lqs_div
// Restoring divider, one quotient bit per cycle, signed result truncated
// toward zero.
// ----------------------------------------------------------------------------
module lqs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [lqs_pkg::SUM_W-1:0] sum,
  input  logic [lqs_pkg::CNT_W-1:0]        divisor,
  output logic                             done,
  output logic signed [lqs_pkg::AVG_W-1:0] quotient
);
  import lqs_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] steps;
  logic [DIV_W-1:0]     quo;
  logic [CNT_W:0]       rem;
  logic [CNT_W-1:0]     dvs;
  logic                 neg;
  logic [SUM_W-1:0]     mag;
  logic [CNT_W:0]       rem_sh;
  logic                 fits;
  logic [DIV_W-1:0]     quo_signed;

  assign mag        = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign rem_sh     = {rem[CNT_W-1:0], quo[DIV_W-1]};
  assign fits       = rem_sh >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = AVG_W'(quo_signed);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract where the divisor fits.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {mag, {FRAC_W{1'b0}}};
      rem <= '0;
      dvs <= divisor;
      neg <= sum[SUM_W-1];
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

[src/linear_queue_with_stats.sv]
// ----------------------------------------------------------------------------
// linear_queue_with_stats
// FIFO of signed 32-bit values with min, max and fixed-point average report.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells with the oldest value in cell 0. Enqueue,
// dequeue and clear each leave one response in the output register. A
// statistics request on a non-empty queue rotates the held entries past
// cell 0, one per cycle, then passes a launch state and the bit-serial
// divider, and the quotient goes to the response register with min and max.
// A new request is taken only once the previous response has left or is
// leaving.
module linear_queue_with_stats (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lqs_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output lqs_pkg::rsp_t out_rsp
);
  import lqs_pkg::*;

`include "assert_macros.svh"

  state_t                  state, state_next;
  logic [CNT_W-1:0]        fill_count;
  logic [CNT_W-1:0]        scan_idx;
  logic signed [VAL_W-1:0] hi, lo;
  logic signed [SUM_W-1:0] sum;
  logic                    accept;
  logic                    out_free;
  logic                    enq_do, deq_do, rot;
  logic                    div_start, div_done;
  logic signed [AVG_W-1:0] div_q;
  logic signed [VAL_W-1:0] cell_q [DEPTH];
  cell_ctl_t               ctl [DEPTH];
  logic                    is_enq, is_deq, is_clear, is_stats;
  logic                    scan_last;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = rst || !(state == S_IDLE && out_free);
  assign accept    = in_valid && !in_stall;
  assign is_enq    = in_req.req_type == REQ_ENQ;
  assign is_deq    = in_req.req_type == REQ_DEQ;
  assign is_clear  = in_req.req_type == REQ_CLEAR;
  assign is_stats  = in_req.req_type == REQ_STATS;
  assign enq_do    = accept && is_enq && (fill_count != CNT_W'(DEPTH));
  assign deq_do    = accept && is_deq && (fill_count != '0);
  assign rot       = state == S_SCAN;
  assign scan_last = scan_idx == fill_count - 1'b1;

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    always_comb begin
      ctl[i].load  = enq_do && (fill_count == CNT_W'(i));
      ctl[i].wrap  = rot && (fill_count - 1'b1 == CNT_W'(i));
      ctl[i].shift = deq_do || rot;
    end
    lqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .in_value   (in_req.value),
      .next_value (nxt),
      .head_value (cell_q[0]),
      .q          (cell_q[i])
    );
  end

  lqs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && is_stats && fill_count != '0) state_next = S_SCAN;
      S_SCAN:   if (scan_last) state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    unique case (state)
      S_LAUNCH: div_start = 1'b1;
      default:  div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (enq_do) begin
          fill_count <= fill_count + 1'b1;
        end else if (deq_do || is_clear) begin
          fill_count <= is_clear ? '0 : fill_count - 1'b1;
        end
        if (!(is_stats && fill_count != '0)) begin
          out_valid <= 1'b1;
        end
      end
      if (state == S_DIV && div_done) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Scan accumulators and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx <= '0;
      hi       <= {1'b1, {(VAL_W-1){1'b0}}};
      lo       <= {1'b0, {(VAL_W-1){1'b1}}};
      sum      <= '0;
    end else if (rot) begin
      scan_idx <= scan_idx + 1'b1;
      if (cell_q[0] > hi) hi <= cell_q[0];
      if (cell_q[0] < lo) lo <= cell_q[0];
      sum <= sum + {{(SUM_W-VAL_W){cell_q[0][VAL_W-1]}}, cell_q[0]};
    end
    if (accept) begin
      out_rsp <= '0;
      case (in_req.req_type)
        REQ_ENQ: begin
          out_rsp.status <= enq_do ? ST_OK : ST_FULL;
          out_rsp.count  <= COUNT_W'(enq_do ? fill_count + 1'b1 : fill_count);
        end
        REQ_DEQ: begin
          out_rsp.status <= deq_do ? ST_OK : ST_EMPTY;
          out_rsp.data   <= deq_do ? cell_q[0] : '0;
          out_rsp.count  <= COUNT_W'(deq_do ? fill_count - 1'b1 : fill_count);
        end
        REQ_CLEAR: begin
          out_rsp.status <= ST_OK;
        end
        default: begin
          out_rsp.status <= (fill_count == '0) ? ST_EMPTY : ST_OK;
          out_rsp.count  <= COUNT_W'(fill_count);
        end
      endcase
    end else if (state == S_DIV && div_done) begin
      out_rsp.max_value <= hi;
      out_rsp.min_value <= lo;
      out_rsp.average   <= div_q;
    end
  end

  `LQS_NEVER(a_count_range, fill_count > CNT_W'(DEPTH), "fill count above depth")
  `LQS_ASSERT(a_busy_stall, state != S_IDLE |-> in_stall, "request taken while busy")
  `LQS_ASSERT(a_scan_hold, state == S_SCAN |=> $stable(fill_count), "count moved in scan")

endmodule

[dv/tb_linear_queue_with_stats.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_queue_with_stats
// Self-checking bench for the queue with min, max and average report.
// ----------------------------------------------------------------------------
// A directed table covers empty corners, clear and the value extremes, then a
// run fills past full and drains past empty. Random phases follow, mostly
// fill/drain runs with stats mixed in, under several idle and stall patterns.
// Every response is checked against a local queue model.
module tb_linear_queue_with_stats;
  import lqs_pkg::*;

  localparam int WATCHDOG = 20000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  req_t  in_req = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  rsp_t  out_rsp;

  linear_queue_with_stats uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  // queue model
  logic signed [VAL_W-1:0] held[$];
  rsp_t pending_rsp[$];
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  int   sent = 0;

  function automatic rsp_t queue_model(req_t r);
    rsp_t o;
    logic signed [63:0] sum, hi, lo, q;
    o = '0;
    case (r.req_type)
      REQ_ENQ: begin
        if (held.size() >= DEPTH) o.status = ST_FULL;
        else held.push_back(r.value);
      end
      REQ_DEQ: begin
        if (held.size() == 0) o.status = ST_EMPTY;
        else o.data = held.pop_front();
      end
      REQ_CLEAR: held.delete();
      default: begin
        if (held.size() == 0) o.status = ST_EMPTY;
        else begin
          hi = held[0];
          lo = held[0];
          sum = 0;
          foreach (held[i]) begin
            if (held[i] > hi) hi = held[i];
            if (held[i] < lo) lo = held[i];
            sum += held[i];
          end
          q = (sum * 256) / $signed(64'(held.size()));
          o.max_value = hi[31:0];
          o.min_value = lo[31:0];
          o.average = q[39:0];
        end
      end
    endcase
    o.count = COUNT_W'(held.size());
    return o;
  endfunction

  // drive one request; hold until accepted
  task automatic send_request(req_code_t op, logic signed [31:0] v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{req_type: op, value: v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp.push_back(queue_model('{req_type: op, value: v}));
    sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // response check and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected response %h", $time, out_rsp);
          errors++;
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (e.status !== out_rsp.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, out_rsp.status);
            errors++;
          end
          if (e.data !== out_rsp.data) begin
            $display("%0t data exp %0d got %0d", $time, e.data, out_rsp.data);
            errors++;
          end
          if (e.count !== out_rsp.count) begin
            $display("%0t count exp %0d got %0d", $time, e.count, out_rsp.count);
            errors++;
          end
          if (e.max_value !== out_rsp.max_value) begin
            $display("%0t max exp %0d got %0d", $time, e.max_value, out_rsp.max_value);
            errors++;
          end
          if (e.min_value !== out_rsp.min_value) begin
            $display("%0t min exp %0d got %0d", $time, e.min_value, out_rsp.min_value);
            errors++;
          end
          if (e.average !== out_rsp.average) begin
            $display("%0t avg exp %0d got %0d", $time, e.average, out_rsp.average);
            errors++;
          end
        end
      end
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on accepted handshakes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("linear_queue_with_stats test failed");
      $finish;
    end
  end

  typedef struct {
    req_code_t         op;
    logic signed [31:0] v;
    logic              typed;
    status_code_t      st;
    logic [7:0]        cnt;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{REQ_DEQ,   0,            1, ST_EMPTY, 0},
    '{REQ_STATS, 0,            1, ST_EMPTY, 0},
    '{REQ_ENQ,   32'h7FFFFFFF, 1, ST_OK,    1},
    '{REQ_ENQ,   32'h80000000, 1, ST_OK,    2},
    '{REQ_STATS, 0,            0, ST_OK,    2},
    '{REQ_ENQ,   -1,           0, ST_OK,    3},
    '{REQ_ENQ,   100,          0, ST_OK,    4},
    '{REQ_STATS, 0,            0, ST_OK,    4},
    '{REQ_DEQ,   0,            0, ST_OK,    3},
    '{REQ_STATS, 0,            0, ST_OK,    3},
    '{REQ_CLEAR, 5,            1, ST_OK,    0},
    '{REQ_STATS, 0,            1, ST_EMPTY, 0},
    '{REQ_ENQ,   -7,           0, ST_OK,    1},
    '{REQ_STATS, 0,            0, ST_OK,    1},
    '{REQ_DEQ,   0,            0, ST_OK,    0},
    '{REQ_DEQ,   0,            1, ST_EMPTY, 0}
  };

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $signed($urandom_range(200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_burst();
    int n;
    n = $urandom_range(1, 12);
    case ($urandom_range(9))
      0, 1, 2, 3: repeat (n) send_request(REQ_ENQ, rand_value());
      4, 5, 6: repeat (n) send_request(REQ_DEQ, rand_value());
      7, 8: send_request(REQ_STATS, rand_value());
      default: send_request($urandom_range(9) == 0 ? REQ_CLEAR : REQ_STATS, rand_value());
    endcase
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].v);
      if (dir_rows[i].typed &&
          (pending_rsp[$].status !== dir_rows[i].st || pending_rsp[$].count !== dir_rows[i].cnt)) begin
        $display("%0t table row %0d exp status %0d count %0d got %0d %0d", $time, i,
                 dir_rows[i].st, dir_rows[i].cnt, pending_rsp[$].status, pending_rsp[$].count);
        errors++;
      end
    end

    // fill to full, overflow, stats over a full queue, then drain past empty
    repeat (DEPTH + 2) send_request(REQ_ENQ, rand_value());
    send_request(REQ_STATS, 0);
    repeat (DEPTH + 2) send_request(REQ_DEQ, 0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        3: begin idle_pct = 30; stall_pct = 30; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      sent = 0;
      while (sent < 330) begin
        random_burst();
        if ($urandom_range(15) == 0) begin
          send_request(REQ_STATS, 0);
          repeat (DEPTH) send_request(REQ_ENQ, rand_value());
          send_request(REQ_STATS, 0);
          send_request(REQ_ENQ, 0);
          send_request(REQ_CLEAR, 0);
        end
      end
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    drop_valid();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("linear_queue_with_stats test passed");
    end else begin
      $display("linear_queue_with_stats test failed");
    end
    $finish;
  end
endmodule
